// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Spectral pair quantiser package
// Shared payload types, field widths and arithmetic constants.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned SampleW = 24;
	localparam int unsigned GainW   = 24;
	localparam int unsigned CodeW   = 16;
	localparam int unsigned LenW    = 11;
	localparam int unsigned MagW    = 15;
	localparam int unsigned ProdW   = 48;
	localparam int unsigned FracW   = 24;

	localparam logic [GainW-1:0] GainReset = 24'd65536;
	// 0.375 in the Q.24 fraction of the product.
	localparam logic [ProdW-1:0] RoundBias = 48'h00_0000_60_0000;
	localparam logic [MagW-1:0]  MagLimit  = 15'd32767;

	typedef struct packed {
		logic signed [SampleW-1:0] sample_first;
		logic signed [SampleW-1:0] sample_second;
		logic                      frame_end;
	} in_item_t;

	typedef struct packed {
		logic [CodeW-1:0] code_first;
		logic [CodeW-1:0] code_second;
		logic             frame_done;
		logic [LenW-1:0]  coded_length;
	} out_item_t;

endpackage

// ----- hw/rtl/spq_lane.sv -----
// ----------------------------------------------------------------------------
// Spectral pair quantiser lane
// Scales one sample by the gain, rounds, saturates and packs the sign code.
// ----------------------------------------------------------------------------
module spq_lane (
	input  logic                                clk,
	input  logic                                en_s1,
	input  logic                                en_s2,
	input  logic signed [spq_pkg::SampleW-1:0]  sample,
	input  logic        [spq_pkg::GainW-1:0]    gain,
	output logic        [spq_pkg::CodeW-1:0]    code
);

	logic                         neg;
	logic [spq_pkg::SampleW:0]    abs_val;
	logic [spq_pkg::ProdW-1:0]    prod_s1;
	logic                         neg_s1;
	logic [spq_pkg::ProdW-1:0]    biased;
	logic [spq_pkg::ProdW-spq_pkg::FracW-1:0] mag_full;
	logic [spq_pkg::MagW-1:0]     mag;
	logic                         sign;
	logic [spq_pkg::CodeW-1:0]    code_s2;

	assign neg     = sample[spq_pkg::SampleW-1];
	assign abs_val = neg ? (spq_pkg::SampleW+1)'(-$signed({sample[spq_pkg::SampleW-1], sample}))
	                     : {1'b0, sample};

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= spq_pkg::ProdW'(abs_val) * spq_pkg::ProdW'(gain);
			neg_s1  <= neg;
		end
	end

	assign biased   = prod_s1 + spq_pkg::RoundBias;
	assign mag_full = biased[spq_pkg::ProdW-1:spq_pkg::FracW];
	assign mag      = (mag_full > (spq_pkg::ProdW-spq_pkg::FracW)'(spq_pkg::MagLimit))
	                ? spq_pkg::MagLimit : mag_full[spq_pkg::MagW-1:0];
	// A result that rounds to zero carries no sign.
	assign sign     = neg_s1 && (mag != '0);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			code_s2 <= {mag, sign};
		end
	end

	assign code = code_s2;

endmodule

// ----- hw/rtl/spq_merge.sv -----
// ----------------------------------------------------------------------------
// Spectral pair quantiser merge stage
// Combines the lane codes, tracks the coded length and holds the result.
// ----------------------------------------------------------------------------
module spq_merge #(
	parameter int unsigned MAX_FRAME_SAMPLES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [spq_pkg::CodeW-1:0]     code_first,
	input  logic [spq_pkg::CodeW-1:0]     code_second,
	input  logic                          frame_end,
	output spq_pkg::out_item_t            result
);

	localparam int unsigned CntW = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam logic [CntW:0] MaxCount = (CntW+1)'(MAX_FRAME_SAMPLES);

	logic [CntW-1:0]          pos_q;
	logic [CntW-1:0]          extent_q;
	logic [CntW:0]            pos_sum;
	logic [CntW-1:0]          pos_next;
	logic [CntW-1:0]          extent_next;
	logic [spq_pkg::LenW-1:0] len_next;
	spq_pkg::out_item_t       result_q;

	assign pos_sum     = {1'b0, pos_q} + (CntW+1)'(2);
	assign pos_next    = (pos_sum > MaxCount) ? MaxCount[CntW-1:0] : pos_sum[CntW-1:0];
	assign extent_next = ((code_first | code_second) != '0) ? pos_next : extent_q;

	generate
		if (CntW >= spq_pkg::LenW) begin : g_len_trunc
			assign len_next = extent_next[spq_pkg::LenW-1:0];
		end else begin : g_len_ext
			assign len_next = {{(spq_pkg::LenW-CntW){1'b0}}, extent_next};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			extent_q <= '0;
		end else if (load) begin
			// The frame's last pair reports its count, then the frame restarts.
			pos_q    <= frame_end ? '0 : pos_next;
			extent_q <= frame_end ? '0 : extent_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.code_first   <= code_first;
			result_q.code_second  <= code_second;
			result_q.frame_done   <= frame_end;
			result_q.coded_length <= len_next;
		end
	end

	assign result = result_q;

endmodule

// ----- hw/rtl/spectral_pair_quantizer_unit.sv -----
// ----------------------------------------------------------------------------
// Each request passes the lane product, lane code and merge result registers.
// Throughput: one request per cycle unless stalled; both lane multipliers are
// pipelined. A stage advances whenever the one after it is empty or moving on.
// Reset clears the gain to 1/256, the frame counters and all valid flags.
// ----------------------------------------------------------------------------
// Spectral pair quantiser
// Two parallel quantiser lanes feeding a merge stage with the length counter.
// ----------------------------------------------------------------------------
module spectral_pair_quantizer_unit #(
	parameter int unsigned MAX_FRAME_SAMPLES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  spq_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output spq_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [spq_pkg::GainW-1:0]   cfg_wdata
);

	logic [spq_pkg::GainW-1:0] gain_q;
	logic                      v_s1;
	logic                      v_s2;
	logic                      out_v_q;
	logic                      last_s1;
	logic                      last_s2;
	logic                      adv_s1;
	logic                      adv_s2;
	logic                      load_s1;
	logic [spq_pkg::CodeW-1:0] code_a;
	logic [spq_pkg::CodeW-1:0] code_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= spq_pkg::GainReset;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	assign adv_s2   = v_s2 && (!out_v_q || out_ready);
	assign adv_s1   = v_s1 && (!v_s2 || adv_s2);
	assign in_ready = !v_s1 || adv_s1;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (!v_s2 || adv_s2) begin
				v_s2 <= v_s1;
			end
			if (!out_v_q || out_ready) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			last_s1 <= in_data.frame_end;
		end
		if (adv_s1) begin
			last_s2 <= last_s1;
		end
	end

	spq_lane u_lane_first (
		.clk    (clk),
		.en_s1  (load_s1),
		.en_s2  (adv_s1),
		.sample (in_data.sample_first),
		.gain   (gain_q),
		.code   (code_a)
	);

	spq_lane u_lane_second (
		.clk    (clk),
		.en_s1  (load_s1),
		.en_s2  (adv_s1),
		.sample (in_data.sample_second),
		.gain   (gain_q),
		.code   (code_b)
	);

	spq_merge #(
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (adv_s2),
		.code_first  (code_a),
		.code_second (code_b),
		.frame_end   (last_s2),
		.result      (out_data)
	);

	assign out_valid = out_v_q;

endmodule

// ----- tb/spectral_pair_quantizer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral pair quantiser testbench
// Drives sample pairs through the quantiser under several gain settings and
// idling patterns, and checks every result against an in-bench prediction of
// the codes and of the coded length of the current frame.
// ----------------------------------------------------------------------------
module spectral_pair_quantizer_unit_tb;

	localparam int unsigned FrameLimit = 1024;
	localparam int unsigned PhaseItems = 200;
	localparam int unsigned HoldCycles = 300;

	class spq_scoreboard;
		logic [spq_pkg::GainW-1:0] gain;
		int unsigned               position;
		int unsigned               extent;
		spq_pkg::out_item_t        pending[$];
		int unsigned               errors;
		int unsigned               results_seen;

		function new();
			gain         = spq_pkg::GainReset;
			position     = 0;
			extent       = 0;
			errors       = 0;
			results_seen = 0;
		endfunction

		function void set_gain(logic [spq_pkg::GainW-1:0] g);
			gain = g;
		endfunction

		function logic [spq_pkg::CodeW-1:0] quantise(logic [spq_pkg::SampleW-1:0] s);
			logic [spq_pkg::SampleW:0] absval;
			logic [spq_pkg::ProdW:0]   scaled;
			logic [spq_pkg::SampleW:0] mag;
			absval = s[spq_pkg::SampleW-1]
				? (spq_pkg::SampleW+1)'((1 << spq_pkg::SampleW) - {1'b0, s})
				: {1'b0, s};
			scaled = absval * gain + {1'b0, spq_pkg::RoundBias};
			mag    = scaled[spq_pkg::ProdW:spq_pkg::FracW];
			if (mag > spq_pkg::MagLimit) begin
				mag = (spq_pkg::SampleW+1)'(spq_pkg::MagLimit);
			end
			// A negative sample that rounds to zero carries no sign.
			return {mag[spq_pkg::MagW-1:0], s[spq_pkg::SampleW-1] && (mag != 0)};
		endfunction

		function void note_request(spq_pkg::in_item_t item);
			spq_pkg::out_item_t want;
			want.code_first  = quantise(item.sample_first);
			want.code_second = quantise(item.sample_second);
			position = (position + 2 > FrameLimit) ? FrameLimit : position + 2;
			if ((want.code_first | want.code_second) != 0) begin
				extent = position;
			end
			want.frame_done   = item.frame_end;
			want.coded_length = extent[spq_pkg::LenW-1:0];
			if (item.frame_end) begin
				position = 0;
				extent   = 0;
			end
			pending.push_back(want);
		endfunction

		task report(string msg);
			if (errors < 40) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
			errors++;
		endtask

		task check_result(spq_pkg::out_item_t got);
			spq_pkg::out_item_t want;
			if (pending.size() == 0) begin
				report("result arrived with no request outstanding");
				return;
			end
			want = pending.pop_front();
			if (got.code_first !== want.code_first) begin
				report($sformatf("result %0d code_first %0d, expected %0d",
					results_seen, got.code_first, want.code_first));
			end
			if (got.code_second !== want.code_second) begin
				report($sformatf("result %0d code_second %0d, expected %0d",
					results_seen, got.code_second, want.code_second));
			end
			if (got.frame_done !== want.frame_done) begin
				report($sformatf("result %0d frame_done %0b, expected %0b",
					results_seen, got.frame_done, want.frame_done));
			end
			if (got.coded_length !== want.coded_length) begin
				report($sformatf("result %0d coded_length %0d, expected %0d",
					results_seen, got.coded_length, want.coded_length));
			end
			results_seen++;
		endtask
	endclass

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	spq_pkg::in_item_t         in_data   = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	spq_pkg::out_item_t        out_data;
	logic                      cfg_we    = 1'b0;
	logic [spq_pkg::GainW-1:0] cfg_wdata = '0;

	spq_scoreboard sb = new();

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	bit          hold_pending  = 1'b0;
	int unsigned hold_left     = 0;

	spectral_pair_quantizer_unit #(
		.MAX_FRAME_SAMPLES(FrameLimit)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Result side: check what was accepted at this edge, then choose the next
	// ready level. A long hold-off lets the pipeline fill and stall its input.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(out_data);
		end
		if (hold_pending) begin
			hold_left    = HoldCycles;
			hold_pending = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_pair(input logic [spq_pkg::SampleW-1:0] first,
			input logic [spq_pkg::SampleW-1:0] second, input logic last);
		spq_pkg::in_item_t item;
		item.sample_first  = first;
		item.sample_second = second;
		item.frame_end     = last;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		sb.note_request(item);
	endtask

	// The gain is only changed once every request has produced its result.
	task automatic write_gain(input logic [spq_pkg::GainW-1:0] g);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_gain(g);
	endtask

	function automatic logic [spq_pkg::SampleW-1:0] random_sample();
		logic [spq_pkg::SampleW-1:0] s;
		case ($urandom_range(0, 3))
			0: begin
				s = '0;
			end
			1: begin
				s = spq_pkg::SampleW'($urandom());
			end
			2: begin
				s = spq_pkg::SampleW'($urandom_range(0, 2047));
			end
			default: begin
				s = spq_pkg::SampleW'($urandom_range(0, 1 << 16));
			end
		endcase
		if ($urandom_range(0, 1)) begin
			s = -s;
		end
		return s;
	endfunction

	initial begin
		int unsigned                 frame_left;
		int unsigned                 long_frames;
		int unsigned                 sent;
		logic [spq_pkg::GainW-1:0]   g;
		logic [spq_pkg::SampleW-1:0] a;
		logic [spq_pkg::SampleW-1:0] b;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset gain of 1/256: extremes, rounding edge and frame ends.
		send_pair(24'sd0, 24'sd0, 1'b0);
		send_pair(24'sd8388607, -24'sd8388608, 1'b0);
		send_pair(24'sd160, -24'sd160, 1'b0);
		send_pair(24'sd159, -24'sd159, 1'b0);
		send_pair(-24'sd1, 24'sd1, 1'b1);
		send_pair(24'sd0, 24'sd0, 1'b1);
		send_pair(24'sd256, 24'sd0, 1'b1);

		// Zero gain gives zero codes and no sign bits.
		write_gain('0);
		send_pair(24'sd8388607, -24'sd8388608, 1'b0);
		send_pair(-24'sd5000, 24'sd777, 1'b0);
		send_pair(24'sd1, -24'sd1, 1'b1);

		// Largest gain: tiny samples become nonzero, large ones saturate.
		write_gain('1);
		send_pair(24'sd1, -24'sd1, 1'b0);
		send_pair(24'sd128, -24'sd129, 1'b0);
		send_pair(-24'sd8388608, 24'sd8388607, 1'b1);

		write_gain(24'd1);
		send_pair(24'sd8388607, -24'sd8388608, 1'b0);
		send_pair(24'sd0, 24'sd0, 1'b1);

		frame_left  = 0;
		long_frames = 0;
		sent        = 0;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					g = spq_pkg::GainReset;
				end
				1: begin
					g = '1;
				end
				2: begin
					g = '0;
				end
				default: begin
					g = phase[0] ? spq_pkg::GainW'($urandom())
					             : spq_pkg::GainW'($urandom_range(1 << 14, 1 << 18));
				end
			endcase
			write_gain(g);
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 62;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 62;
				end
				default: begin
					send_idle_pct = 27;
					stall_pct     = 27;
				end
			endcase
			if (phase == 4) begin
				hold_pending = 1'b1;
			end
			for (int n = 0; n < PhaseItems; n++) begin
				// Mostly short frames; of two long ones, one reaches the frame limit and one passes it.
				if (frame_left == 0) begin
					if (long_frames < 2 && sent >= 300 + 600 * long_frames) begin
						frame_left = long_frames ? 560 : FrameLimit / 2;
						long_frames++;
					end else begin
						frame_left = $urandom_range(1, 40);
					end
				end
				frame_left--;
				if ($urandom_range(0, 99) < 15) begin
					a = '0;
					b = '0;
				end else begin
					a = random_sample();
					b = random_sample();
				end
				send_pair(a, b, frame_left == 0);
				sent++;
			end
		end

		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
